FILE: design/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
`default_nettype none
package dvrt_pkg;

    localparam int ID_W        = 3;
    localparam int DIST_W      = 6;
    localparam int RESULT_CAP  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [DIST_W-1:0] DIST_MAX  = 6'd63;
    localparam logic [DIST_W-1:0] DIST_LINK = 6'd1;
    localparam logic [DIST_W-1:0] DIST_SELF = 6'd0;

    typedef enum logic [1:0] {
        FUNC_VECTOR    = 2'd0,
        FUNC_LINK_UP   = 2'd1,
        FUNC_LINK_DOWN = 2'd2,
        FUNC_ADVERTISE = 2'd3
    } t_func;

    // one input beat
    typedef struct packed {
        t_func              func;
        logic [ID_W-1:0]    sender;
        logic [ID_W-1:0]    dest;
        logic [DIST_W-1:0]  dist_req;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [ID_W-1:0]    entry_dest;
        logic [ID_W-1:0]    entry_next_hop;
        logic [DIST_W-1:0]  entry_dist;
        logic               reachable;
        logic               changed;
        logic               last;
    } t_result;

    // classified command handed from front to back
    typedef struct packed {
        t_func              func;
        logic [ID_W-1:0]    sender;
        logic [ID_W-1:0]    dest;
        logic [DIST_W-1:0]  cand;
        logic               dest_self;
        logic               dest_in;
        logic               sender_self;
    } t_cmd;

endpackage
`default_nettype wire

FILE: design/dvrt_fifo.sv
// Small register queue used between the pipeline parts.
`default_nettype none
module dvrt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/dvrt_front.sv
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none
module dvrt_front #(
    parameter int MAX_NODES = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [dvrt_pkg::ID_W-1:0] i_self_id,
    input  wire logic                   i_push,
    input  wire dvrt_pkg::t_item        i_item,
    output logic                        o_full,
    input  wire logic                   i_pop,
    output dvrt_pkg::t_cmd              o_cmd,
    output logic                        o_empty
);
    dvrt_pkg::t_cmd cmd;
    logic [$bits(dvrt_pkg::t_cmd)-1:0] head;

    // decode ids against this router and the table size, saturate distance
    always_comb begin
        cmd.func        = i_item.func;
        cmd.sender      = i_item.sender;
        cmd.dest        = i_item.dest;
        cmd.cand        = (i_item.dist_req == dvrt_pkg::DIST_MAX) ? dvrt_pkg::DIST_MAX
                                                                  : i_item.dist_req + 1'b1;
        cmd.dest_self   = (i_item.dest == i_self_id);
        cmd.dest_in     = !cmd.dest_self && (int'(i_item.dest) < MAX_NODES);
        cmd.sender_self = (i_item.sender == i_self_id);
    end

    dvrt_fifo #(
        .W     ($bits(dvrt_pkg::t_cmd)),
        .DEPTH (dvrt_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (head),
        .o_empty (o_empty)
    );

    assign o_cmd = dvrt_pkg::t_cmd'(head);

endmodule
`default_nettype wire

FILE: design/dvrt_back.sv
// Back end: route table storage, updates and advertise walk.
`default_nettype none
module dvrt_back #(
    parameter int MAX_NODES = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [dvrt_pkg::ID_W-1:0] i_self_id,
    input  wire dvrt_pkg::t_cmd            i_cmd,
    input  wire logic                      i_cmd_empty,
    output logic                           o_cmd_pop,
    output logic                           o_res_push,
    output dvrt_pkg::t_result              o_res,
    input  wire logic                      i_res_full
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(dvrt_pkg::RESULT_CAP);
    localparam logic [CW-1:0] CNT_LAST = CW'(dvrt_pkg::RESULT_CAP - 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_NODES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ADV
    } t_state;

    t_state                       r_state;
    dvrt_pkg::t_cmd               r_cmd;
    logic [IW-1:0]                r_idx;
    logic [CW-1:0]                r_cnt;
    logic [MAX_NODES-1:0]         r_valid;

    logic [dvrt_pkg::ID_W-1:0]    r_hop_mem  [MAX_NODES];
    logic [dvrt_pkg::DIST_W-1:0]  r_dist_mem [MAX_NODES];
    logic [dvrt_pkg::ID_W-1:0]    r_rd_hop;
    logic [dvrt_pkg::DIST_W-1:0]  r_rd_dist;

    logic [IW-1:0]                rd_addr;
    logic [IW-1:0]                di;
    logic                         mem_we;
    logic                         old_valid;
    logic                         new_valid;
    logic [dvrt_pkg::ID_W-1:0]    new_hop;
    logic [dvrt_pkg::DIST_W-1:0]  new_dist;
    logic                         chg;
    logic                         take;
    logic [MAX_NODES-1:0]         reach_mask;
    logic [MAX_NODES-1:0]         above;
    logic                         adv_reach;
    logic                         adv_more;
    logic                         adv_last;
    logic                         adv_self;
    logic                         adv_emit;
    logic                         adv_done;
    dvrt_pkg::t_result            exec_res;
    dvrt_pkg::t_result            adv_res;

    assign di        = IW'(r_cmd.dest);
    assign old_valid = r_valid[di];

    // read-modify-write decision for one update command
    always_comb begin
        new_valid = old_valid;
        new_hop   = r_rd_hop;
        new_dist  = r_rd_dist;
        chg       = 1'b0;
        mem_we    = 1'b0;
        take      = 1'b0;
        if (r_cmd.dest_in) begin
            case (r_cmd.func)
                dvrt_pkg::FUNC_VECTOR: begin
                    take = !r_cmd.sender_self && (!old_valid || r_cmd.cand < r_rd_dist);
                    if (take) begin
                        chg       = !old_valid || r_rd_hop != r_cmd.sender
                                    || r_rd_dist != r_cmd.cand;
                        new_valid = 1'b1;
                        new_hop   = r_cmd.sender;
                        new_dist  = r_cmd.cand;
                        mem_we    = 1'b1;
                    end
                end
                dvrt_pkg::FUNC_LINK_UP: begin
                    chg       = !old_valid || r_rd_hop != r_cmd.dest
                                || r_rd_dist != dvrt_pkg::DIST_LINK;
                    new_valid = 1'b1;
                    new_hop   = r_cmd.dest;
                    new_dist  = dvrt_pkg::DIST_LINK;
                    mem_we    = 1'b1;
                end
                dvrt_pkg::FUNC_LINK_DOWN: begin
                    chg       = old_valid;
                    new_valid = 1'b0;
                end
                default: begin
                    chg = 1'b0;
                end
            endcase
        end
    end

    // result of an update command
    always_comb begin
        exec_res.entry_dest = r_cmd.dest;
        exec_res.changed    = chg;
        exec_res.last       = 1'b1;
        if (r_cmd.dest_self) begin
            exec_res.reachable      = 1'b1;
            exec_res.entry_next_hop = i_self_id;
            exec_res.entry_dist     = dvrt_pkg::DIST_SELF;
        end else if (r_cmd.dest_in && new_valid) begin
            exec_res.reachable      = 1'b1;
            exec_res.entry_next_hop = new_hop;
            exec_res.entry_dist     = new_dist;
        end else begin
            exec_res.reachable      = 1'b0;
            exec_res.entry_next_hop = '0;
            exec_res.entry_dist     = '0;
        end
    end

    // advertise walk: reachable set and lookahead for the last beat
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            reach_mask[i] = r_valid[i] || (int'(i_self_id) == i);
        end
        above     = (reach_mask >> r_idx) >> 1;
        adv_reach = reach_mask[r_idx];
        adv_more  = |above;
        adv_last  = !adv_more || (r_cnt == CNT_LAST);
        adv_self  = (int'(i_self_id) == int'(r_idx));
        adv_emit  = (r_state == S_ADV) && adv_reach && !i_res_full;
        adv_done  = (adv_emit && adv_last) || (!adv_reach && !adv_more)
                    || (r_idx == IDX_LAST && (adv_emit || !adv_reach));

        adv_res.entry_dest     = dvrt_pkg::ID_W'(r_idx);
        adv_res.entry_next_hop = adv_self ? i_self_id : r_rd_hop;
        adv_res.entry_dist     = adv_self ? dvrt_pkg::DIST_SELF : r_rd_dist;
        adv_res.reachable      = 1'b1;
        adv_res.changed        = 1'b0;
        adv_res.last           = adv_last;
    end

    // handshakes toward both queues and table read address
    always_comb begin
        o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
        o_res_push = 1'b0;
        o_res      = exec_res;
        rd_addr    = r_idx;
        case (r_state)
            S_IDLE: begin
                rd_addr = (i_cmd.func == dvrt_pkg::FUNC_ADVERTISE) ? '0 : IW'(i_cmd.dest);
            end
            S_EXEC: begin
                o_res_push = !i_res_full;
                rd_addr    = di;
            end
            S_ADV: begin
                o_res_push = adv_emit;
                o_res      = adv_res;
                if (adv_emit || !adv_reach) begin
                    rd_addr = r_idx + 1'b1;
                end
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    // control state and valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_valid <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_cnt <= '0;
                        r_state <= (i_cmd.func == dvrt_pkg::FUNC_ADVERTISE) ? S_ADV : S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!i_res_full) begin
                        if (r_cmd.dest_in) begin
                            r_valid[di] <= new_valid;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_ADV: begin
                    if (adv_done) begin
                        r_state <= S_IDLE;
                    end else if (adv_emit || !adv_reach) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (adv_emit) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // next hop and distance storage, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && !i_res_full && mem_we) begin
            r_hop_mem[di]  <= new_hop;
            r_dist_mem[di] <= new_dist;
        end
        r_rd_hop  <= r_hop_mem[rd_addr];
        r_rd_dist <= r_dist_mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: design/distance_vector_route_table_top.sv
// Path: a link or vector beat passes the command queue, the back end's EXEC state and the result queue.
// Back end: link and vector beats take a table read, then update and result, and a new
// command is taken only back in IDLE; an advertise beat walks the table, one table entry
// per cycle through the single table read port while the result queue is not full.
// Reset: synchronous, active low; clears both queues, all route marks and self_id to 0.
// Next hop and distance storage is not cleared; entries are used only while marked.
`default_nettype none
module distance_vector_route_table_top #(
    parameter int MAX_NODES = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [dvrt_pkg::ID_W-1:0] i_cfg_wdata,
    input  wire logic                      push,
    input  wire dvrt_pkg::t_item           i_item,
    output logic                           full,
    input  wire logic                      pop,
    output dvrt_pkg::t_result              o_result,
    output logic                           empty
);
    logic [dvrt_pkg::ID_W-1:0] r_self_id;
    dvrt_pkg::t_cmd            cmd;
    logic                      cmd_empty;
    logic                      cmd_pop;
    logic                      res_push;
    dvrt_pkg::t_result         res;
    logic                      res_full;
    logic [$bits(dvrt_pkg::t_result)-1:0] res_head;

    // this router's id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= '0;
        end else if (i_cfg_we) begin
            r_self_id <= i_cfg_wdata;
        end
    end

    dvrt_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_self_id (r_self_id),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_pop     (cmd_pop),
        .o_cmd     (cmd),
        .o_empty   (cmd_empty)
    );

    dvrt_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_self_id   (r_self_id),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // result queue
    dvrt_fifo #(
        .W     ($bits(dvrt_pkg::t_result)),
        .DEPTH (dvrt_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_result = dvrt_pkg::t_result'(res_head);

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && res_full))
        else $error("result beat pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_pop && cmd_empty))
        else $error("command popped from empty queue");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.reachable) |->
        (o_result.entry_next_hop == '0 && o_result.entry_dist == '0))
        else $error("unreachable result carries route data");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |=> !cmd_pop)
        else $error("back end took two commands back to back");
`endif

endmodule
`default_nettype wire

FILE: bench/distance_vector_route_table_top_tb.sv
// Self-checking bench for the distance-vector route table: directed rows, then random beats.
`default_nettype none
module distance_vector_route_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES    = 8;
    localparam int STALL_LIMIT  = 400;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 58;

    // one row of the directed walk; want is used only where typed is set
    typedef struct packed {
        dvrt_pkg::t_item   item;
        logic              typed;
        dvrt_pkg::t_result want;
    } t_directed_row;

    // self id is 0 out of reset for all of these rows
    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{'{dvrt_pkg::FUNC_ADVERTISE, 3'd0, 3'd0, 6'd0},
          1'b1, '{3'd0, 3'd0, 6'd0,  1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_DOWN, 3'd0, 3'd3, 6'd0},
          1'b1, '{3'd3, 3'd0, 6'd0,  1'b0, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd2, 3'd5, 6'd0},
          1'b1, '{3'd5, 3'd2, 6'd1,  1'b1, 1'b1, 1'b1}},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd3, 3'd5, 6'd0},
          1'b1, '{3'd5, 3'd2, 6'd1,  1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd1, 3'd6, 6'd63},
          1'b1, '{3'd6, 3'd1, 6'd63, 1'b1, 1'b1, 1'b1}},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd4, 3'd6, 6'd62},
          1'b1, '{3'd6, 3'd1, 6'd63, 1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd4, 3'd6, 6'd61}, 1'b0, '0},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd7, 3'd5, 6'd63}, 1'b0, '0},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd0, 3'd7, 6'd5},
          1'b1, '{3'd7, 3'd0, 6'd0,  1'b0, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd2, 3'd0, 6'd5},
          1'b1, '{3'd0, 3'd0, 6'd0,  1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd0, 3'd0, 6'd0},
          1'b1, '{3'd0, 3'd0, 6'd0,  1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_DOWN, 3'd0, 3'd0, 6'd0},
          1'b1, '{3'd0, 3'd0, 6'd0,  1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd0, 3'd7, 6'd0},
          1'b1, '{3'd7, 3'd7, 6'd1,  1'b1, 1'b1, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd0, 3'd7, 6'd0},
          1'b1, '{3'd7, 3'd7, 6'd1,  1'b1, 1'b0, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_DOWN, 3'd0, 3'd6, 6'd0},
          1'b1, '{3'd6, 3'd0, 6'd0,  1'b0, 1'b1, 1'b1}},
        '{'{dvrt_pkg::FUNC_LINK_DOWN, 3'd0, 3'd6, 6'd0},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd5, 3'd1, 6'd33}, 1'b0, '0},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd0, 3'd2, 6'd0},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd0, 3'd3, 6'd0},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_LINK_UP,   3'd0, 3'd4, 6'd0},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd7, 3'd6, 6'd3},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_ADVERTISE, 3'd0, 3'd0, 6'd0},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_VECTOR,    3'd1, 3'd5, 6'd0},  1'b0, '0},
        '{'{dvrt_pkg::FUNC_LINK_DOWN, 3'd7, 3'd7, 6'd63}, 1'b0, '0},
        '{'{dvrt_pkg::FUNC_ADVERTISE, 3'd7, 3'd7, 6'd63}, 1'b0, '0}
    };

    // self ids of the random phases; the last phase draws its own
    localparam logic [dvrt_pkg::ID_W-1:0] PHASE_SELF [NUM_PHASES] =
        '{3'd7, 3'd0, 3'd2, 3'd5, 3'd0};

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [dvrt_pkg::ID_W-1:0]   i_cfg_wdata = '0;
    logic                        push        = 1'b0;
    dvrt_pkg::t_item             i_item      = '0;
    logic                        full;
    logic                        pop         = 1'b0;
    dvrt_pkg::t_result           o_result;
    logic                        empty;

    // predictor copy of the route table
    logic [dvrt_pkg::ID_W-1:0]   route_hop   [MAX_NODES] = '{default: '0};
    logic [dvrt_pkg::DIST_W-1:0] route_dist  [MAX_NODES] = '{default: '0};
    logic                        route_known [MAX_NODES] = '{default: 1'b0};
    logic [dvrt_pkg::ID_W-1:0]   node_self   = '0;

    dvrt_pkg::t_result           fresh_reports   [$];
    dvrt_pkg::t_result           pending_reports [$];
    int unsigned                 mismatch_count = 0;
    int unsigned                 stall_count    = 0;
    bit                          quiet_send     = 1'b0;
    bit                          quiet_recv     = 1'b0;

    distance_vector_route_table_top #(
        .MAX_NODES(MAX_NODES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .pop        (pop),
        .o_result   (o_result),
        .empty      (empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // what the table reports for one destination right now
    function automatic dvrt_pkg::t_result entry_report(input logic [dvrt_pkg::ID_W-1:0] d,
                                                       input logic chg, input logic lst);
        dvrt_pkg::t_result r;
        r = '0;
        r.entry_dest = d;
        r.changed    = chg;
        r.last       = lst;
        if (d == node_self) begin
            r.entry_next_hop = node_self;
            r.entry_dist     = dvrt_pkg::DIST_SELF;
            r.reachable      = 1'b1;
        end else if (route_known[d]) begin
            r.entry_next_hop = route_hop[d];
            r.entry_dist     = route_dist[d];
            r.reachable      = 1'b1;
        end
        return r;
    endfunction

    // apply one beat to the table copy and list the result beats it causes
    function automatic void predict_routes(input dvrt_pkg::t_item it);
        logic [dvrt_pkg::DIST_W-1:0] cand;
        logic                        chg;
        dvrt_pkg::t_result           tail;
        int                          i;
        fresh_reports.delete();
        chg = 1'b0;
        if (it.func == dvrt_pkg::FUNC_ADVERTISE) begin
            for (i = 0; i < MAX_NODES; i++) begin
                if ((dvrt_pkg::ID_W'(i) == node_self || route_known[i]) &&
                    fresh_reports.size() < dvrt_pkg::RESULT_CAP) begin
                    fresh_reports.push_back(entry_report(dvrt_pkg::ID_W'(i), 1'b0, 1'b0));
                end
            end
            if (fresh_reports.size() != 0) begin
                tail      = fresh_reports[fresh_reports.size() - 1];
                tail.last = 1'b1;
                fresh_reports[fresh_reports.size() - 1] = tail;
            end
            return;
        end
        // distance via the sender, saturating
        cand = (it.dist_req == dvrt_pkg::DIST_MAX) ? dvrt_pkg::DIST_MAX
                                                   : it.dist_req + 1'b1;
        if (it.dest != node_self) begin
            case (it.func)
                dvrt_pkg::FUNC_VECTOR: begin
                    if (it.sender != node_self &&
                        (!route_known[it.dest] || cand < route_dist[it.dest])) begin
                        chg = !route_known[it.dest] || route_hop[it.dest] != it.sender ||
                              route_dist[it.dest] != cand;
                        route_hop[it.dest]   = it.sender;
                        route_dist[it.dest]  = cand;
                        route_known[it.dest] = 1'b1;
                    end
                end
                dvrt_pkg::FUNC_LINK_UP: begin
                    chg = !route_known[it.dest] || route_hop[it.dest] != it.dest ||
                          route_dist[it.dest] != dvrt_pkg::DIST_LINK;
                    route_hop[it.dest]   = it.dest;
                    route_dist[it.dest]  = dvrt_pkg::DIST_LINK;
                    route_known[it.dest] = 1'b1;
                end
                default: begin
                    chg = route_known[it.dest];
                    route_known[it.dest] = 1'b0;
                end
            endcase
        end
        fresh_reports.push_back(entry_report(it.dest, chg, 1'b1));
    endfunction

    // drive one input beat after a random gap and log what it should produce
    task automatic send_item(input dvrt_pkg::t_item it, input logic typed,
                             input dvrt_pkg::t_result want);
        int unsigned gap;
        gap = quiet_send ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 31) == 0) quiet_send = !quiet_send;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_routes(it);
        if (typed) begin
            pending_reports.push_back(want);
        end else begin
            foreach (fresh_reports[k]) pending_reports.push_back(fresh_reports[k]);
        end
    endtask

    task automatic flag_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // stimulus: reset, directed rows, then random phases, each with its own self id write
    initial begin : stimulus
        dvrt_pkg::t_item           it;
        int unsigned               roll;
        logic [dvrt_pkg::ID_W-1:0] self_next;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
        end
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // self id changes only while the table is idle
            push <= 1'b0;
            while (pending_reports.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            self_next   = (ph == NUM_PHASES - 1) ? dvrt_pkg::ID_W'($urandom_range(0, 7))
                                                 : PHASE_SELF[ph];
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= self_next;
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            node_self   = self_next;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mostly vector beats with short distances so routes keep improving
                roll      = $urandom_range(0, 99);
                it.func   = (roll < 50) ? dvrt_pkg::FUNC_VECTOR :
                            (roll < 68) ? dvrt_pkg::FUNC_LINK_UP :
                            (roll < 82) ? dvrt_pkg::FUNC_LINK_DOWN : dvrt_pkg::FUNC_ADVERTISE;
                it.sender = dvrt_pkg::ID_W'($urandom_range(0, 7));
                it.dest   = dvrt_pkg::ID_W'($urandom_range(0, 7));
                it.dist_req = ($urandom_range(0, 3) == 0) ?
                              dvrt_pkg::DIST_W'($urandom_range(0, 63)) :
                              dvrt_pkg::DIST_W'($urandom_range(0, 6));
                send_item(it, 1'b0, '0);
            end
        end
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side: random pop stalls, each beat checked against the oldest expectation
    initial begin : result_side
        int unsigned       stall;
        dvrt_pkg::t_result got;
        dvrt_pkg::t_result want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = quiet_recv ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0) quiet_recv = !quiet_recv;
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = o_result;
            if (pending_reports.size() == 0) begin
                $display("%0t ns: result beat expected none, got %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                flag_field("entry_dest",     8'(want.entry_dest),     8'(got.entry_dest));
                flag_field("entry_next_hop", 8'(want.entry_next_hop), 8'(got.entry_next_hop));
                flag_field("entry_dist",     8'(want.entry_dist),     8'(got.entry_dist));
                flag_field("reachable",      8'(want.reachable),      8'(got.reachable));
                flag_field("changed",        8'(want.changed),        8'(got.changed));
                flag_field("last",           8'(want.last),           8'(got.last));
            end
        end
    end

    // cycles since the last beat moved on either side
    always_ff @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin : watchdog
        while (stall_count < STALL_LIMIT) @(posedge i_clk);
        $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
